FILE: rtl/lcg48_pkg.sv
package lcg48_pkg;

  localparam logic [47:0] LcgMult = 48'h0005_DEEC_E66D;
  localparam logic [47:0] LcgInc = 48'h0000_0000_000B;
  localparam logic [30:0] NarrowMax = 31'h7FFF_FFFF;
  localparam logic [62:0] WideMax = 63'h7FFF_FFFF_FFFF_FFFF;
  localparam int WeightLimit = 24;

  // sequencer states
  typedef enum logic [10:0] {
    S_IDLE    = 11'b000_0000_0001,
    S_LIMIT   = 11'b000_0000_0010,
    S_STEP    = 11'b000_0000_0100,
    S_CHECK   = 11'b000_0000_1000,
    S_POW     = 11'b000_0001_0000,
    S_DIV     = 11'b000_0010_0000,
    S_KEEP    = 11'b000_0100_0000,
    S_WSTEP   = 11'b000_1000_0000,
    S_WCHECK  = 11'b001_0000_0000,
    S_ADD     = 11'b010_0000_0000,
    S_OUT     = 11'b100_0000_0000
  } state_t;

  // divider control
  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [32:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [32:0] remainder;
  } div_rsp_t;

endpackage

FILE: rtl/lcg48_step.sv
module lcg48_step
  import lcg48_pkg::*;
(
  input  logic        clk,
  input  logic [47:0] cur,
  input  logic        start,
  output logic        done,
  output logic [47:0] nxt
);

  // two-stage 48x48 multiply, low half only, split into 24-bit partials
  logic [47:0] p_lo;
  logic [23:0] p_hi;
  logic        v1;

  always_ff @(posedge clk) begin
    p_lo <= cur * LcgMult[23:0];
    p_hi <= cur[23:0] * LcgMult[47:24];
    v1 <= start;
    done <= v1;
    nxt <= p_lo + {p_hi, 24'd0} + LcgInc;
  end

endmodule

FILE: rtl/lcg48_div.sv
module lcg48_div
  import lcg48_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  // restoring divider, one quotient bit a cycle
  logic [63:0] quo;
  logic [32:0] rem;
  logic [32:0] dsr;
  logic [6:0]  cnt;
  logic        busy;
  logic        done;
  logic [33:0] trial;

  assign trial = {rem, quo[63]} - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        quo <= req.dividend;
        rem <= '0;
        dsr <= req.divisor;
        cnt <= 7'd0;
      end else if (busy) begin
        if (!trial[33]) begin
          rem <= trial[32:0];
          quo <= {quo[62:0], 1'b1};
        end else begin
          rem <= {rem[31:0], quo[63]};
          quo <= {quo[62:0], 1'b0};
        end
        cnt <= cnt + 7'd1;
        if (cnt == 7'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.remainder = rem;

endmodule

FILE: rtl/lcg48_bounded_random_draw.sv
// channel  | dir | beat content
// s_axis   | in  | tdata: range_low[31:0] range_high[63:32] weight[69:64] wide[70]
// m_axis   | out | tdata: value[31:0]; tuser: error
// cfg      | in  | data: seed_value[47:0]
// an error item skips the generator and divider; otherwise each generator step runs through the
// two-stage multiplier, each limit and remainder through the serial divider,
// and rejected draws and weighted draws repeat the step and remainder
// rst is synchronous; generator state clears to zero, reloaded by each cfg write
// s_axis_tready is low while an item is in flight; a result held on m_axis stalls the next
module lcg48_bounded_random_draw
  import lcg48_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // range_low, range_high, weight, wide
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // value
  output logic        m_axis_tuser,   // error
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [47:0] cfg_data
);

  state_t      state;
  logic [47:0] lcg;
  logic [31:0] lo;
  logic [32:0] n;
  logic        wide;
  logic        keep_max;
  logic [4:0]  left;
  logic [62:0] limit;
  logic [62:0] b;
  logic [30:0] r;
  logic        first;
  logic        half;
  div_req_t    dreq;
  div_rsp_t    drsp;
  logic        sdone;
  logic [47:0] snxt;
  logic        sstart;

  logic signed [31:0] in_lo, in_hi;
  logic signed [5:0]  in_w;
  logic signed [32:0] diff;
  logic [4:0]         wsat;
  logic [30:0]        t;
  logic [61:0]        pw;

  assign in_lo = s_axis_tdata[31:0];
  assign in_hi = s_axis_tdata[63:32];
  assign in_w = s_axis_tdata[69:64];
  assign diff = 33'(in_hi) - 33'(in_lo);

  // saturate the weight magnitude
  always_comb begin
    if (in_w > 6'sd24 || in_w < -6'sd24) wsat = 5'(WeightLimit);
    else if (in_w < 0) wsat = 5'(-in_w);
    else wsat = in_w[4:0];
  end

  assign cfg_ready = (state == S_IDLE) && !m_axis_tvalid;
  assign s_axis_tready = (state == S_IDLE) && !m_axis_tvalid && !cfg_valid;

  lcg48_step u_step (.clk(clk), .cur(lcg), .start(sstart), .done(sdone), .nxt(snxt));
  lcg48_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  assign pw = 62'(n[30:0]) * 62'(b[30:0]);
  assign t = drsp.remainder[30:0];

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      lcg <= '0;
      m_axis_tvalid <= 1'b0;
      sstart <= 1'b0;
      dreq.start <= 1'b0;
    end else begin
      sstart <= 1'b0;
      dreq.start <= 1'b0;
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (cfg_valid && cfg_ready) lcg <= cfg_data;
          else if (s_axis_tvalid && s_axis_tready) begin
            lo <= in_lo;
            n <= diff[32:0] + 33'd1;
            wide <= s_axis_tdata[70];
            keep_max <= !in_w[5];
            left <= wsat;
            first <= 1'b1;
            if (diff[32] || (!s_axis_tdata[70] && diff[31:0] >= 32'h7FFF_FFFF)) begin
              m_axis_tdata <= '0;
              m_axis_tuser <= 1'b1;
              m_axis_tvalid <= 1'b1;
            end else begin
              state <= S_LIMIT;
              dreq.start <= 1'b1;
              dreq.dividend <= s_axis_tdata[70] ? {1'b0, WideMax} : {33'd0, NarrowMax};
              dreq.divisor <= diff[32:0] + 33'd1;
            end
          end
        end
        S_LIMIT: begin
          // largest multiple of n not above the max is the max less its remainder
          if (drsp.done) begin
            limit <= wide ? WideMax - {30'd0, drsp.remainder}
                          : {32'd0, NarrowMax} - {30'd0, drsp.remainder};
            state <= S_STEP;
            sstart <= 1'b1;
            half <= 1'b0;
          end
        end
        S_STEP: begin
          if (sdone) begin
            lcg <= snxt;
            if (wide && !half) begin
              b <= {snxt[47:17], 32'd0};
              half <= 1'b1;
              sstart <= 1'b1;
            end else begin
              if (wide) b <= b ^ {31'd0, snxt[47:16]};
              else b <= {32'd0, snxt[47:17]};
              state <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          if (!wide && (n[30:0] & (n[30:0] - 31'd1)) == 31'd0) state <= S_POW;
          else if (b >= limit) begin
            state <= S_STEP;
            sstart <= 1'b1;
            half <= 1'b0;
          end else begin
            state <= S_DIV;
            dreq.start <= 1'b1;
            dreq.dividend <= {1'b0, b};
            dreq.divisor <= n;
          end
        end
        S_POW: begin
          if (first || (keep_max ? pw[61:31] > r : pw[61:31] < r)) r <= pw[61:31];
          state <= S_KEEP;
        end
        S_DIV: begin
          if (drsp.done) begin
            if (wide) begin
              r <= 31'd0;
              m_axis_tdata <= lo + drsp.remainder[31:0];
              m_axis_tuser <= 1'b0;
              state <= S_OUT;
            end else begin
              if (first || (keep_max ? t > r : t < r)) r <= t;
              state <= S_KEEP;
            end
          end
        end
        S_KEEP: begin
          first <= 1'b0;
          if (left != 5'd0) begin
            left <= left - 5'd1;
            state <= S_STEP;
            sstart <= 1'b1;
            half <= 1'b0;
          end else state <= S_ADD;
        end
        S_ADD: begin
          m_axis_tdata <= lo + {1'b0, r};
          m_axis_tuser <= 1'b0;
          state <= S_OUT;
        end
        S_OUT: begin
          m_axis_tvalid <= 1'b1;
          state <= S_IDLE;
        end
        S_WSTEP, S_WCHECK: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !s_axis_tready) else $error("ready while busy");
  a_out_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) |=> (state == S_IDLE && m_axis_tvalid)) else $error("output lost");
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |-> !cfg_ready || !cfg_valid) else $error("cfg clash");

endmodule
